// ===== rtl/hpr_pkg.sv =====
// Shared types, constants and arctangent table for the pose integrator.
`timescale 1ns / 1ps
package hpr_pkg;

  localparam int CordicStagesDefault = 16;
  localparam int AtanLen             = 24;

  localparam logic [14:0]        StepTimeReset = 15'd6554;
  localparam logic signed [31:0] RadToPhase    = 32'sd683565276;
  localparam logic signed [33:0] CordicGain    = 34'sd652032875;
  // floor(t / 3) == (t * Recip3) >> Recip3Shift for any 32-bit t
  localparam logic [31:0]        Recip3        = 32'hAAAAAAAB;
  localparam int                 Recip3Shift   = 33;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } hpr_lane_t;

  // one slot of the rotator chain: three headings plus the pose carried along
  typedef struct packed {
    logic               valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] vf;
    logic signed [15:0] vl;
    logic [15:0]        hd;
    hpr_lane_t [2:0]    lane;
  } hpr_cell_t;

  function automatic logic [31:0] atan_phase(input int idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/holonomic_pose_rk4_integrator_core.sv =====
// Top level of the RK4 holonomic pose integrator.
//
// Input channel (in_valid_i / in_ready_o) carries a pose and a body-frame
// command; output channel (out_valid_o / out_ready_i) returns the advanced
// pose. One result per input, in order.
// cfg_we_i writes the 15-bit step time; write only while the block is idle.
// Throughput: one item per cycle. Every stage is a register, so the pipeline
// takes a new transfer every cycle while results are being taken.
// The pipeline has 3 angle stages, one CORDIC cell per stage, and 7 multiply,
// scaling and saturation stages ending in the output reg.
// Stages above 24 are treated as 24.
// Reset empties the pipeline and loads the step time with its default.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops
// until the waiting result is transferred.
`timescale 1ns / 1ps
module holonomic_pose_rk4_integrator_core #(
  parameter int CORDIC_STAGES = hpr_pkg::CordicStagesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] vel_forward_i,
  input  logic signed [15:0] vel_lateral_i,
  input  logic signed [15:0] turn_rate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] next_x_o,
  output logic signed [31:0] next_y_o,
  output logic signed [15:0] next_heading_o,
  output logic               saturated_o
);
  import hpr_pkg::*;

  localparam int NumCells = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;

  logic [14:0] step_time_q;
  logic        en;
  hpr_cell_t   chain [NumCells+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q <= StepTimeReset;
    end else if (cfg_we_i) begin
      step_time_q <= cfg_wdata_i;
    end
  end

  hpr_angle_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .step_time_i   (step_time_q),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .heading_i     (heading_i),
    .vel_forward_i (vel_forward_i),
    .vel_lateral_i (vel_lateral_i),
    .turn_rate_i   (turn_rate_i),
    .cell_o        (chain[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    hpr_cordic_cell #(.Stage(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  hpr_rate_combine u_combine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .step_time_i    (step_time_q),
    .cell_i         (chain[NumCells]),
    .out_valid_o    (out_valid_o),
    .next_x_o       (next_x_o),
    .next_y_o       (next_y_o),
    .next_heading_o (next_heading_o),
    .saturated_o    (saturated_o)
  );

`ifndef SYNTHESIS
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (next_x_o == 32'sh7FFF_FFFF) || (next_x_o == 32'sh8000_0000) ||
      (next_y_o == 32'sh7FFF_FFFF) || (next_y_o == 32'sh8000_0000))
    else $error("saturated flag without a clamped position");

  a_no_sat_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (next_x_o != 32'sh7FFF_FFFF) && (next_x_o != 32'sh8000_0000) &&
      (next_y_o != 32'sh7FFF_FFFF) && (next_y_o != 32'sh8000_0000) |-> !saturated_o)
    else $error("saturated flag on an unclamped result");
`endif

endmodule

// ===== rtl/hpr_angle_prep.sv =====
// Turning angle, the three rotation phases and the wrapped output heading.
`timescale 1ns / 1ps
module hpr_angle_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [14:0]        step_time_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] vel_forward_i,
  input  logic signed [15:0] vel_lateral_i,
  input  logic signed [15:0] turn_rate_i,
  output hpr_pkg::hpr_cell_t cell_o
);
  import hpr_pkg::*;

  logic               v1_q, v2_q;
  logic signed [31:0] px1_q, py1_q, px2_q, py2_q;
  logic signed [15:0] vf1_q, vl1_q, vf2_q, vl2_q;
  logic [15:0]        yaw1_q, yaw2_q;
  logic signed [31:0] prod1_d, prod1_q;
  logic signed [63:0] prod2_d, prod2_q;
  hpr_cell_t          cell_d, cell_q;

  assign prod1_d = 32'(turn_rate_i) * 32'($signed({1'b0, step_time_i}));
  assign prod2_d = 64'(prod1_q) * 64'(RadToPhase);

  always_comb begin
    logic [63:0] full_r, half_r;
    logic [31:0] yaw32, full, half;
    logic [31:0] ph [3];
    logic [31:0] hsum;
    logic [31:0] a;
    full_r = prod2_q + (64'd1 << 27);
    half_r = prod2_q + (64'd1 << 28);
    full   = full_r[59:28];
    half   = half_r[60:29];
    yaw32  = {yaw2_q, 16'h0000};
    ph[0]  = yaw32;
    ph[1]  = yaw32 + half;
    ph[2]  = yaw32 + full;
    hsum   = yaw32 + full + 32'h0000_8000;
    cell_d.valid = v2_q;
    cell_d.px    = px2_q;
    cell_d.py    = py2_q;
    cell_d.vf    = vf2_q;
    cell_d.vl    = vl2_q;
    cell_d.hd    = hsum[31:16];
    for (int l = 0; l < 3; l++) begin
      // left half plane: rotate by half a turn, negate the result later
      a = ph[l];
      cell_d.lane[l].flip = a[31] ^ a[30];
      if (cell_d.lane[l].flip) a = a ^ 32'h8000_0000;
      cell_d.lane[l].z = 34'($signed(a));
      cell_d.lane[l].x = CordicGain;
      cell_d.lane[l].y = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      cell_q <= '0;
    end else if (en_i) begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      cell_q <= cell_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px1_q   <= pos_x_i;
      py1_q   <= pos_y_i;
      yaw1_q  <= heading_i;
      vf1_q   <= vel_forward_i;
      vl1_q   <= vel_lateral_i;
      prod1_q <= prod1_d;
      px2_q   <= px1_q;
      py2_q   <= py1_q;
      yaw2_q  <= yaw1_q;
      vf2_q   <= vf1_q;
      vl2_q   <= vl1_q;
      prod2_q <= prod2_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/hpr_cordic_cell.sv =====
// One rotation-mode CORDIC stage applied to three headings at once.
`timescale 1ns / 1ps
module hpr_cordic_cell #(
  parameter int Stage = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  hpr_pkg::hpr_cell_t cell_i,
  output hpr_pkg::hpr_cell_t cell_o
);
  import hpr_pkg::*;

  localparam logic signed [33:0] Atan = $signed({2'b00, atan_phase(Stage)});

  hpr_cell_t cell_d, cell_q;

  always_comb begin
    logic signed [33:0] xs, ys;
    cell_d = cell_i;
    for (int l = 0; l < 3; l++) begin
      xs = cell_i.lane[l].x >>> Stage;
      ys = cell_i.lane[l].y >>> Stage;
      if (!cell_i.lane[l].z[33]) begin
        cell_d.lane[l].x = cell_i.lane[l].x - ys;
        cell_d.lane[l].y = cell_i.lane[l].y + xs;
        cell_d.lane[l].z = cell_i.lane[l].z - Atan;
      end else begin
        cell_d.lane[l].x = cell_i.lane[l].x + ys;
        cell_d.lane[l].y = cell_i.lane[l].y - xs;
        cell_d.lane[l].z = cell_i.lane[l].z + Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/hpr_rate_combine.sv =====
// World-frame rates, RK4 weighting, scaling by dt/6 and saturating update.
`timescale 1ns / 1ps
module hpr_rate_combine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [14:0]        step_time_i,
  input  hpr_pkg::hpr_cell_t cell_i,
  output logic               out_valid_o,
  output logic signed [31:0] next_x_o,
  output logic signed [31:0] next_y_o,
  output logic signed [15:0] next_heading_o,
  output logic               saturated_o
);
  import hpr_pkg::*;

  localparam int Depth = 6;

  logic [Depth-1:0]   v_q;
  logic signed [31:0] px_q [Depth];
  logic signed [31:0] py_q [Depth];
  logic [15:0]        hd_q [Depth];

  logic signed [49:0] pa_d [3][4], pa_q [3][4];
  logic signed [50:0] kx_q [3], ky_q [3];
  logic signed [41:0] sx_d, sy_d, sx_q, sy_q;
  logic signed [57:0] p_d [2], p_q [2];
  logic [26:0]        t_d [2], t_q [2];
  logic [1:0]         neg_d, neg_q;
  logic signed [27:0] dl_d [2], dl_q [2];
  logic signed [33:0] sum_x, sum_y;
  logic signed [31:0] nx_d, ny_d;
  logic               sat_d;

  logic               vout_q, sat_q;
  logic signed [31:0] nx_q, ny_q;
  logic [15:0]        hdo_q;

  // products of the body velocity with cos and sin of each heading
  always_comb begin
    logic signed [33:0] c, s;
    for (int l = 0; l < 3; l++) begin
      c = cell_i.lane[l].flip ? -cell_i.lane[l].x : cell_i.lane[l].x;
      s = cell_i.lane[l].flip ? -cell_i.lane[l].y : cell_i.lane[l].y;
      pa_d[l][0] = 50'(cell_i.vf) * 50'(c);
      pa_d[l][1] = 50'(cell_i.vl) * 50'(s);
      pa_d[l][2] = 50'(cell_i.vf) * 50'(s);
      pa_d[l][3] = 50'(cell_i.vl) * 50'(c);
    end
  end

  always_comb begin
    logic signed [53:0] ax, ay;
    ax = 54'(kx_q[0]) + (54'(kx_q[1]) <<< 2) + 54'(kx_q[2]) + 54'sd2048;
    ay = 54'(ky_q[0]) + (54'(ky_q[1]) <<< 2) + 54'(ky_q[2]) + 54'sd2048;
    sx_d = ax[53:12];
    sy_d = ay[53:12];
  end

  assign p_d[0] = 58'(sx_q) * 58'($signed({1'b0, step_time_i}));
  assign p_d[1] = 58'(sy_q) * 58'($signed({1'b0, step_time_i}));

  // divide by 6 * 2^30, half away from zero: floor((|p| + 3*2^30) / 2^31) / 3
  always_comb begin
    logic [57:0] m;
    logic [58:0] q;
    for (int i = 0; i < 2; i++) begin
      neg_d[i] = p_q[i][57];
      m        = (neg_d[i] ? 58'(-p_q[i]) : 58'(p_q[i])) + (58'd3 << 30);
      t_d[i]   = m[57:31];
      q        = 59'(t_q[i]) * 59'(Recip3);
      dl_d[i]  = neg_q[i] ? -$signed({2'b00, q[58:Recip3Shift]})
                          :  $signed({2'b00, q[58:Recip3Shift]});
    end
  end

  always_comb begin
    sum_x = 34'(px_q[Depth-1]) + 34'(dl_q[0]);
    sum_y = 34'(py_q[Depth-1]) + 34'(dl_q[1]);
    sat_d = 1'b0;
    if (sum_x > 34'sh0_7FFF_FFFF) begin
      nx_d = 32'sh7FFF_FFFF; sat_d = 1'b1;
    end else if (sum_x < -34'sh0_8000_0000) begin
      nx_d = 32'sh8000_0000; sat_d = 1'b1;
    end else begin
      nx_d = sum_x[31:0];
    end
    if (sum_y > 34'sh0_7FFF_FFFF) begin
      ny_d = 32'sh7FFF_FFFF; sat_d = 1'b1;
    end else if (sum_y < -34'sh0_8000_0000) begin
      ny_d = 32'sh8000_0000; sat_d = 1'b1;
    end else begin
      ny_d = sum_y[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      v_q    <= {v_q[Depth-2:0], cell_i.valid};
      vout_q <= v_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q[0] <= cell_i.px;
      py_q[0] <= cell_i.py;
      hd_q[0] <= cell_i.hd;
      for (int i = 1; i < Depth; i++) begin
        px_q[i] <= px_q[i-1];
        py_q[i] <= py_q[i-1];
        hd_q[i] <= hd_q[i-1];
      end
      pa_q <= pa_d;
      for (int l = 0; l < 3; l++) begin
        kx_q[l] <= 51'(pa_q[l][0]) - 51'(pa_q[l][1]);
        ky_q[l] <= 51'(pa_q[l][2]) + 51'(pa_q[l][3]);
      end
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      p_q   <= p_d;
      t_q   <= t_d;
      neg_q <= neg_d;
      dl_q  <= dl_d;
      nx_q  <= nx_d;
      ny_q  <= ny_d;
      sat_q <= sat_d;
      hdo_q <= hd_q[Depth-1];
    end
  end

  assign out_valid_o    = vout_q;
  assign next_x_o       = nx_q;
  assign next_y_o       = ny_q;
  assign next_heading_o = hdo_q;
  assign saturated_o    = sat_q;

endmodule
